@@ rtl/assert_macros.svh @@
// assertion macros used by the checker file fevq_checker.sv
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed: property does not hold");

// condition in one cycle implies consequence in the next
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle consequence missing");

`endif

@@ rtl/fevq_pkg.sv @@
// shared types and constants for the filtered event queue
// no dependencies
package fevq_pkg;

  localparam int DEPTH       = 64;
  localparam int PTR_W       = $clog2(DEPTH);
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int PAYLOAD_W   = 32;
  localparam int SEQ_W       = 32;
  localparam int DROP_W      = 32;
  localparam int TYPE_W      = 4;
  localparam int MASK_W      = 16;
  localparam int CAP_W       = 7;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int DEFAULT_CAP = 32;

  // input modes
  localparam logic [1:0] MODE_ENQ = 2'd0;
  localparam logic [1:0] MODE_DEQ = 2'd1;
  localparam logic [1:0] MODE_CLR = 2'd2;

  // result status codes
  localparam logic [2:0] ST_STORED  = 3'd0;
  localparam logic [2:0] ST_UNSUB   = 3'd1;
  localparam logic [2:0] ST_CAPDROP = 3'd2;
  localparam logic [2:0] ST_POPPED  = 3'd3;
  localparam logic [2:0] ST_EMPTY   = 3'd4;
  localparam logic [2:0] ST_CLEARED = 3'd5;
  localparam logic [2:0] ST_FULL    = 3'd6;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SUBSCRIBED = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LIFECYCLE  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SOFT_CAP   = 2'd2;

  localparam logic [MASK_W-1:0] SUBSCRIBED_RESET = 16'd1;
  localparam logic [MASK_W-1:0] LIFECYCLE_RESET  = 16'd17;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_LOAD
  } state_t;

  // controller to datapath commands
  typedef struct packed {
    logic capture;
    logic exec;
    logic load_out;
  } dp_cmd_t;

endpackage

@@ rtl/fevq_datapath.sv @@
// datapath of the filtered event queue: config, store, pointers, counters, result regs
// depends on fevq_pkg
module fevq_datapath (
  input  logic                                 clk,
  input  logic                                 rst,
  input  fevq_pkg::dp_cmd_t                    cmd,
  input  logic                                 cfg_write,
  input  logic [fevq_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [fevq_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic [1:0]                           mode,
  input  logic [fevq_pkg::TYPE_W-1:0]          event_type,
  input  logic [fevq_pkg::PAYLOAD_W-1:0]       event_payload,
  output logic [2:0]                           status,
  output logic [fevq_pkg::TYPE_W-1:0]          out_type,
  output logic [fevq_pkg::PAYLOAD_W-1:0]       out_payload,
  output logic [fevq_pkg::SEQ_W-1:0]           out_sequence,
  output logic [fevq_pkg::CNT_W-1:0]           queue_count,
  output logic [fevq_pkg::DROP_W-1:0]          drop_total
);

  localparam int ENTRY_W = fevq_pkg::TYPE_W + fevq_pkg::SEQ_W + fevq_pkg::PAYLOAD_W;

  logic [fevq_pkg::MASK_W-1:0]    subscribed_mask;
  logic [fevq_pkg::MASK_W-1:0]    lifecycle_mask;
  logic [fevq_pkg::CAP_W-1:0]     soft_cap;

  logic [1:0]                     mode_q;
  logic [fevq_pkg::TYPE_W-1:0]    type_q;
  logic [fevq_pkg::PAYLOAD_W-1:0] payload_q;

  logic [ENTRY_W-1:0]             mem [fevq_pkg::DEPTH];
  logic [ENTRY_W-1:0]             rd_data;

  logic [fevq_pkg::PTR_W-1:0]     head_ptr;
  logic [fevq_pkg::PTR_W-1:0]     tail_ptr;
  logic [fevq_pkg::CNT_W-1:0]     fill_count;
  logic [fevq_pkg::SEQ_W-1:0]     next_seq;
  logic [fevq_pkg::DROP_W-1:0]    drop_counter;

  logic [2:0]                     res_status;
  logic [fevq_pkg::SEQ_W-1:0]     res_seq;
  logic                           res_pop;

  logic                           is_enq;
  logic                           is_clr;
  logic                           subscribed;
  logic                           lifecycle;
  logic                           cap_hit;
  logic                           full;
  logic                           empty;
  logic                           wr_en;
  logic                           rd_en;
  logic                           bump;
  logic [2:0]                     status_next;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      subscribed_mask <= fevq_pkg::SUBSCRIBED_RESET;
      lifecycle_mask  <= fevq_pkg::LIFECYCLE_RESET;
      soft_cap        <= fevq_pkg::CAP_W'(fevq_pkg::DEFAULT_CAP);
    end else if (cfg_write) begin
      case (cfg_index)
        fevq_pkg::CFG_SUBSCRIBED: subscribed_mask <= cfg_data;
        fevq_pkg::CFG_LIFECYCLE:  lifecycle_mask  <= cfg_data;
        fevq_pkg::CFG_SOFT_CAP:   soft_cap        <= cfg_data[fevq_pkg::CAP_W-1:0];
        default: ;
      endcase
    end
  end

  // input capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_q    <= mode;
      type_q    <= event_type;
      payload_q <= event_payload;
    end
  end

  // decision for the captured item
  always_comb begin
    is_enq     = (mode_q == fevq_pkg::MODE_ENQ);
    is_clr     = (mode_q == fevq_pkg::MODE_CLR);
    subscribed = subscribed_mask[type_q];
    lifecycle  = lifecycle_mask[type_q];
    cap_hit    = (32'(fill_count) >= 32'(soft_cap));
    full       = (fill_count == fevq_pkg::CNT_W'(fevq_pkg::DEPTH));
    empty      = (fill_count == '0);
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    bump       = 1'b0;
    if (is_enq) begin
      if (!subscribed) begin
        status_next = fevq_pkg::ST_UNSUB;
      end else if (cap_hit && !lifecycle) begin
        status_next = fevq_pkg::ST_CAPDROP;
        bump        = 1'b1;
      end else if (full) begin
        status_next = fevq_pkg::ST_FULL;
        bump        = 1'b1;
      end else begin
        status_next = fevq_pkg::ST_STORED;
        wr_en       = cmd.exec;
      end
    end else if (is_clr) begin
      status_next = fevq_pkg::ST_CLEARED;
    end else if (empty) begin
      status_next = fevq_pkg::ST_EMPTY;
    end else begin
      status_next = fevq_pkg::ST_POPPED;
      rd_en       = cmd.exec;
    end
  end

  // entry store, registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[tail_ptr] <= {type_q, next_seq, payload_q};
    end
    if (rd_en) begin
      rd_data <= mem[head_ptr];
    end
  end

  // pointers and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      head_ptr     <= '0;
      tail_ptr     <= '0;
      fill_count   <= '0;
      next_seq     <= '0;
      drop_counter <= '0;
    end else if (cmd.exec) begin
      if (is_clr) begin
        head_ptr   <= '0;
        tail_ptr   <= '0;
        fill_count <= '0;
      end
      if (wr_en) begin
        tail_ptr   <= tail_ptr + 1'b1;
        fill_count <= fill_count + 1'b1;
        next_seq   <= next_seq + 1'b1;
      end
      if (rd_en) begin
        head_ptr   <= head_ptr + 1'b1;
        fill_count <= fill_count - 1'b1;
      end
      if (bump && (drop_counter != '1)) begin
        drop_counter <= drop_counter + 1'b1;
      end
    end
  end

  // staged result fields
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_status <= status_next;
      res_seq    <= wr_en ? next_seq : '0;
      res_pop    <= rd_en;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      status       <= res_status;
      out_type     <= res_pop ? rd_data[ENTRY_W-1 -: fevq_pkg::TYPE_W] : '0;
      out_sequence <= res_pop ? rd_data[fevq_pkg::PAYLOAD_W +: fevq_pkg::SEQ_W] : res_seq;
      out_payload  <= res_pop ? rd_data[fevq_pkg::PAYLOAD_W-1:0] : '0;
      queue_count  <= fill_count;
      drop_total   <= drop_counter;
    end
  end

endmodule

@@ rtl/fevq_ctrl.sv @@
// controller of the filtered event queue: item sequencing and output valid
// depends on fevq_pkg
module fevq_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output fevq_pkg::dp_cmd_t cmd
);

  fevq_pkg::state_t state;
  fevq_pkg::state_t state_next;
  logic             out_free;

  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= fevq_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      fevq_pkg::S_IDLE: if (in_valid) state_next = fevq_pkg::S_EXEC;
      fevq_pkg::S_EXEC: state_next = fevq_pkg::S_LOAD;
      fevq_pkg::S_LOAD: if (out_free) state_next = fevq_pkg::S_IDLE;
      default:          state_next = fevq_pkg::S_IDLE;
    endcase
  end

  // outputs, nothing is taken while reset is held
  always_comb begin
    in_ready     = 1'b0;
    cmd.capture  = 1'b0;
    cmd.exec     = 1'b0;
    cmd.load_out = 1'b0;
    case (state)
      fevq_pkg::S_IDLE: begin
        in_ready    = !rst;
        cmd.capture = in_valid && !rst;
      end
      fevq_pkg::S_EXEC: cmd.exec = 1'b1;
      fevq_pkg::S_LOAD: cmd.load_out = out_free;
      default: ;
    endcase
  end

  // output valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

@@ rtl/filtered_event_fifo_with_drop_core.sv @@
// top level of the filtered event queue with tail drop
// depends on fevq_pkg, fevq_ctrl, fevq_datapath
//
// usage
//   input channel in_valid/in_ready carries one item: mode (enqueue, dequeue,
//   clear), event_type and event_payload
//   output channel out_valid/out_ready returns exactly one result per item:
//   status, popped type/payload, sequence number, count after the step and
//   the saturating drop total
//   config port: cfg_write with cfg_index 0 subscribed mask, 1 lifecycle mask,
//   2 soft cap; writes land at once; user writes only while idle, unchecked
// sequencing
//   an accepted item runs capture, execute, load: the result and out_valid
//   are registered when the load step finds the output free
//   one item in flight; no new item is taken until the last one has loaded
//   the single-port 64-entry store with its registered read sets the
//   execute-then-load sequence
// reset and stall
//   rst (sync, active high) empties the queue, zeroes sequence and drop
//   counters and restores the default config; the store itself is not cleared
//   a stalled receiver holds the result in the output register; the next
//   item may still be accepted and executed, then waits to load
module filtered_event_fifo_with_drop_core (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [fevq_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [fevq_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [1:0]                           mode,
  input  logic [fevq_pkg::TYPE_W-1:0]          event_type,
  input  logic [fevq_pkg::PAYLOAD_W-1:0]       event_payload,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [2:0]                           status,
  output logic [fevq_pkg::TYPE_W-1:0]          out_type,
  output logic [fevq_pkg::PAYLOAD_W-1:0]       out_payload,
  output logic [fevq_pkg::SEQ_W-1:0]           out_sequence,
  output logic [fevq_pkg::CNT_W-1:0]           queue_count,
  output logic [fevq_pkg::DROP_W-1:0]          drop_total
);

  // commands from the sequencer to the datapath
  fevq_pkg::dp_cmd_t cmd;

  // item sequencing and output valid
  fevq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  // config, store, pointers, counters and result registers
  fevq_datapath u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .cfg_write     (cfg_write),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .mode          (mode),
    .event_type    (event_type),
    .event_payload (event_payload),
    .status        (status),
    .out_type      (out_type),
    .out_payload   (out_payload),
    .out_sequence  (out_sequence),
    .queue_count   (queue_count),
    .drop_total    (drop_total)
  );

endmodule

@@ rtl/fevq_checker.sv @@
// port-level checks for the filtered event queue, bound to the top level
// depends on fevq_pkg and assert_macros.svh
`include "assert_macros.svh"

module fevq_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [2:0]                      status,
  input logic [fevq_pkg::CNT_W-1:0]      queue_count
);

  // held result stays while the receiver stalls
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(status))

  // one item in flight: no accept right after an accept
  `ASSERT_NEXT(a_one_in_flight, clk, rst, in_valid && in_ready, !in_ready)

  // a clear always reports an empty queue
  `ASSERT_ALWAYS(a_clear_empty, clk, rst,
    !(out_valid && (status == fevq_pkg::ST_CLEARED)) || (queue_count == '0))

  // occupancy never exceeds the store
  `ASSERT_ALWAYS(a_count_bound, clk, rst,
    !out_valid || (32'(queue_count) <= fevq_pkg::DEPTH))

endmodule

bind filtered_event_fifo_with_drop_core fevq_checker u_fevq_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .status      (status),
  .queue_count (queue_count)
);
